// ----- sv/wheel_ground_contact_force_top_defines.svh -----
// Assertion macros shared by the wheel contact block.
`ifndef WHEEL_GROUND_CONTACT_FORCE_TOP_DEFINES_SVH
`define WHEEL_GROUND_CONTACT_FORCE_TOP_DEFINES_SVH

// Assert that an implication holds at every clock edge outside reset.
`define WGC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that the consequent holds in the cycle after the antecedent.
`define WGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wgc_pkg.sv -----
package wgc_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_MOUNT_X   = 3'd0,
    REG_MOUNT_Y   = 3'd1,
    REG_STIFFNESS = 3'd2,
    REG_DAMPING   = 3'd3,
    REG_BRAKES    = 3'd4
  } reg_idx_e;

  localparam int unsigned   ANG_SHIFT   = 13;
  localparam logic [33:0]   PI_Q29      = 34'd1686629713;
  localparam logic [33:0]   HALF_PI_Q29 = 34'd843314857;
  localparam logic [30:0]   GAIN_Q30    = 31'd652032874;
  localparam logic [29:0]   ROLL_Q32    = 30'd383032992;
  localparam logic [32:0]   BRAKE_Q32   = 33'd3006477107;

  // Wide datapath word for the rotator.
  typedef logic signed [35:0] cw_t;
  typedef logic signed [33:0] ang_t;

  // One CORDIC cell's state.
  typedef struct packed {
    cw_t  x;
    cw_t  y;
    ang_t z;
  } rot_t;

  // Arctangent table, Q2.29.
  function automatic logic [29:0] atan_q29(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_q29 = 30'd421657428;
      5'd1:  atan_q29 = 30'd248918915;
      5'd2:  atan_q29 = 30'd131521918;
      5'd3:  atan_q29 = 30'd66762579;
      5'd4:  atan_q29 = 30'd33510843;
      5'd5:  atan_q29 = 30'd16771758;
      5'd6:  atan_q29 = 30'd8387925;
      5'd7:  atan_q29 = 30'd4194219;
      5'd8:  atan_q29 = 30'd2097141;
      5'd9:  atan_q29 = 30'd1048575;
      5'd30: atan_q29 = 30'd0;
      default: atan_q29 = 30'd1 << (5'd29 - i);
    endcase
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -96'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

// ----- sv/wgc_cordic_cell.sv -----
// One micro-rotation of the CORDIC chain with its sideband item data.
module wgc_cordic_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SBW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  wgc_pkg::rot_t      rot_i,
  input  logic [SBW-1:0]     sb_i,
  output logic               valid_o,
  output wgc_pkg::rot_t      rot_o,
  output logic [SBW-1:0]     sb_o
);

  logic          valid_q;
  wgc_pkg::rot_t rot_q, rot_d;
  logic [SBW-1:0] sb_q;
  wgc_pkg::cw_t  dx, dy;
  wgc_pkg::ang_t at;

  // Floor shifts and the rotation direction from the residual angle.
  always_comb begin
    dx = rot_i.y >>> IDX;
    dy = rot_i.x >>> IDX;
    at = wgc_pkg::ang_t'({4'd0, wgc_pkg::atan_q29(5'(IDX))});
    rot_d = rot_i;
    if (!rot_i.z[33]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - at;
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
      sb_q  <= sb_i;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign sb_o    = sb_q;

endmodule

// ----- sv/wheel_ground_contact_force_top.sv -----
// Ground contact of one landing-gear wheel; one item per cycle unless held.
// Input channel: in_valid_i / in_stall_o with the body state fields; an item
// is taken at a clock edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with force_x_o, force_y_o,
// torque_out_o, in_contact_o and crashed_o; one result item per input item.
// Between acceptance and out_valid_o: one pre-rotation cell, CORDIC_STAGES
// rotation cells, seven arithmetic stages for gain, depth, spin speed,
// vertical speed, damping, normal force and friction/torque, then the
// output register. Reset clears the configuration registers and pipeline
// valid bits, not the data. Throughput is one item per cycle unless stalled.
// The whole pipeline advances as one: when out_stall_i holds a result and
// the output register is full, every stage holds and in_stall_o rises;
// otherwise items keep flowing, even with a result waiting in the output.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i by the
// user only while the block is idle; the block does not enforce this.
`include "wheel_ground_contact_force_top_defines.svh"
module wheel_ground_contact_force_top #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] body_x_i,
  input  logic signed [31:0] body_y_i,
  input  logic signed [31:0] spin_rate_i,
  input  logic signed [18:0] attitude_i,
  input  logic [30:0]        body_mass_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] torque_out_o,
  output logic               in_contact_o,
  output logic               crashed_o
);

  localparam int unsigned SBW = 32 + 32 + 32 + 32 + 31;

  // Configuration registers.
  logic signed [31:0] mount_x_q, mount_y_q;
  logic [30:0]        stiff_q, damp_q;
  logic               brakes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mount_x_q <= '0;
      mount_y_q <= '0;
      stiff_q   <= '0;
      damp_q    <= '0;
      brakes_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wgc_pkg::REG_MOUNT_X:   mount_x_q <= cfg_data_i;
        wgc_pkg::REG_MOUNT_Y:   mount_y_q <= cfg_data_i;
        wgc_pkg::REG_STIFFNESS: stiff_q   <= cfg_data_i[30:0];
        wgc_pkg::REG_DAMPING:   damp_q    <= cfg_data_i[30:0];
        wgc_pkg::REG_BRAKES:    brakes_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Global advance: hold everything only when a full output is stalled.
  logic en;
  logic out_v_q;
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // Pre-rotation cell: fold the angle into plus or minus pi/2.
  wgc_pkg::rot_t  pre_d, pre_q;
  logic           pre_v_q;
  logic [SBW-1:0] pre_sb_q;
  wgc_pkg::ang_t  z0;

  always_comb begin
    z0 = wgc_pkg::ang_t'(attitude_i) <<< wgc_pkg::ANG_SHIFT;
    pre_d.x = wgc_pkg::cw_t'(mount_x_q);
    pre_d.y = wgc_pkg::cw_t'(mount_y_q);
    pre_d.z = z0;
    if (z0 > $signed(wgc_pkg::HALF_PI_Q29)) begin
      pre_d.x = -wgc_pkg::cw_t'(mount_x_q);
      pre_d.y = -wgc_pkg::cw_t'(mount_y_q);
      pre_d.z = z0 - $signed(wgc_pkg::PI_Q29);
    end else if (z0 < -$signed(wgc_pkg::HALF_PI_Q29)) begin
      pre_d.x = -wgc_pkg::cw_t'(mount_x_q);
      pre_d.y = -wgc_pkg::cw_t'(mount_y_q);
      pre_d.z = z0 + $signed(wgc_pkg::PI_Q29);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pre_v_q <= 1'b0;
    else if (en) pre_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q    <= pre_d;
      pre_sb_q <= {vel_x_i, vel_y_i, body_y_i, spin_rate_i, body_mass_i};
    end
  end

  // Chain of rotation cells.
  logic           cv [CORDIC_STAGES+1];
  wgc_pkg::rot_t  cr [CORDIC_STAGES+1];
  logic [SBW-1:0] cs [CORDIC_STAGES+1];

  assign cv[0] = pre_v_q;
  assign cr[0] = pre_q;
  assign cs[0] = pre_sb_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    wgc_cordic_cell #(.IDX(g), .SBW(SBW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(cv[g]), .rot_i(cr[g]), .sb_i(cs[g]),
      .valid_o(cv[g+1]), .rot_o(cr[g+1]), .sb_o(cs[g+1])
    );
  end

  logic signed [31:0] e_vx, e_vy, e_by, e_sr;
  logic [30:0]        e_m;
  assign {e_vx, e_vy, e_by, e_sr, e_m} = cs[CORDIC_STAGES];

  // Stage A: gain multiply.
  logic               a_v_q;
  logic signed [67:0] a_gx_q, a_gy_q;
  logic signed [31:0] a_vx_q, a_vy_q, a_by_q, a_sr_q;
  logic [30:0]        a_m_q;

  // Stage B: round, saturate, depth.
  logic               b_v_q;
  logic signed [31:0] b_rx_q, b_dep_q, b_vx_q, b_vy_q, b_sr_q;
  logic [30:0]        b_m_q;

  // Stage C: spin speed product, stiffness product.
  logic               c_v_q;
  logic signed [63:0] c_sp_q, c_kp_q;
  logic signed [31:0] c_dep_q, c_vx_q, c_vy_q;
  logic [30:0]        c_m_q;

  // Stage D: vertical speed, then its damping product in stage E.
  logic               d_v_q;
  logic signed [31:0] d_vs_q, d_dep_q, d_vx_q;
  logic signed [63:0] d_kp_q;
  logic [30:0]        d_m_q;

  logic               e_v_q;
  logic signed [63:0] e_dp_q, e_kp_q;
  logic signed [31:0] e_dep_q, e_vx_q;
  logic [30:0]        e_m_q;

  // Stage F: normal force and rolling friction.
  logic               f_v_q;
  logic signed [31:0] f_n_q, f_dep_q, f_vx_q;
  logic [31:0]        f_roll_q;

  // Stage G: brake and torque products.
  logic               g_v_q;
  logic signed [31:0] g_n_q, g_dep_q, g_vx_q;
  logic [31:0]        g_roll_q;
  logic signed [65:0] g_bp_q;
  logic signed [63:0] g_tp_q;

  logic signed [31:0] b_rx_d, b_ry_d, d_vs_d, f_n_d;
  logic signed [63:0] f_kr, f_dr;
  logic signed [33:0] brake;
  logic signed [33:0] mag;
  logic signed [31:0] fx_d, tq_d, ny_d;
  logic               con_d, crash_d;

  always_comb begin
    b_rx_d = wgc_pkg::sat32(96'(a_gx_q + 68'sd536870912) >>> 30);
    b_ry_d = wgc_pkg::sat32(96'(a_gy_q + 68'sd536870912) >>> 30);
    d_vs_d = wgc_pkg::sat32(96'(wgc_pkg::sat32(96'(c_sp_q + 64'sd32768) >>> 16))
             + 96'(c_vy_q));
    f_kr   = (e_kp_q + 64'sd32768) >>> 16;
    f_dr   = (e_dp_q + 64'sd32768) >>> 16;
    f_n_d  = wgc_pkg::sat32(96'(f_kr) - 96'(f_dr));
    brake  = 34'((g_bp_q + 66'sd2147483648) >>> 32);
    mag    = $signed({2'b00, g_roll_q}) + (brakes_q ? brake : 34'sd0);
    fx_d   = 32'sd0;
    if (g_vx_q != 32'sd0) begin
      fx_d = (g_vx_q > 32'sd0) ? wgc_pkg::sat32(-96'(mag)) : wgc_pkg::sat32(96'(mag));
    end
    tq_d   = wgc_pkg::sat32(96'(g_tp_q + 64'sd32768) >>> 16);
    con_d  = !(g_dep_q > 32'sd0);
    crash_d = con_d && (g_dep_q < mount_y_q);
    ny_d   = g_n_q;
    if (!con_d || crash_d) begin
      fx_d = '0;
      ny_d = '0;
      tq_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0; b_v_q <= 1'b0; c_v_q <= 1'b0; d_v_q <= 1'b0;
      e_v_q <= 1'b0; f_v_q <= 1'b0; g_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= cv[CORDIC_STAGES];
      b_v_q <= a_v_q; c_v_q <= b_v_q; d_v_q <= c_v_q;
      e_v_q <= d_v_q; f_v_q <= e_v_q; g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_gx_q <= 68'(cr[CORDIC_STAGES].x) * $signed({1'b0, wgc_pkg::GAIN_Q30});
      a_gy_q <= 68'(cr[CORDIC_STAGES].y) * $signed({1'b0, wgc_pkg::GAIN_Q30});
      a_vx_q <= e_vx; a_vy_q <= e_vy; a_by_q <= e_by; a_sr_q <= e_sr; a_m_q <= e_m;

      b_rx_q  <= b_rx_d;
      b_dep_q <= wgc_pkg::sat32(96'(b_ry_d) + 96'(a_by_q));
      b_vx_q <= a_vx_q; b_vy_q <= a_vy_q; b_sr_q <= a_sr_q; b_m_q <= a_m_q;

      c_sp_q  <= 64'(b_sr_q) * 64'(b_rx_q);
      c_kp_q  <= -(64'(b_dep_q) * $signed({33'd0, stiff_q}));
      c_dep_q <= b_dep_q; c_vx_q <= b_vx_q; c_vy_q <= b_vy_q; c_m_q <= b_m_q;

      d_vs_q <= d_vs_d; d_kp_q <= c_kp_q; d_dep_q <= c_dep_q;
      d_vx_q <= c_vx_q; d_m_q <= c_m_q;

      e_dp_q  <= 64'(d_vs_q) * $signed({33'd0, damp_q});
      e_kp_q  <= d_kp_q; e_dep_q <= d_dep_q; e_vx_q <= d_vx_q; e_m_q <= d_m_q;

      f_n_q    <= f_n_d;
      f_roll_q <= 32'((({31'd0, e_m_q} * {32'd0, wgc_pkg::ROLL_Q32}) + 61'h80000000) >> 32);
      f_dep_q  <= e_dep_q; f_vx_q <= e_vx_q;

      g_bp_q  <= 66'(f_n_q) * $signed({1'b0, wgc_pkg::BRAKE_Q32});
      g_tp_q  <= 64'(f_n_q) * 64'(mount_x_q);
      g_n_q   <= f_n_q; g_dep_q <= f_dep_q; g_vx_q <= f_vx_q; g_roll_q <= f_roll_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= g_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      force_x_o    <= fx_d;
      force_y_o    <= ny_d;
      torque_out_o <= tq_d;
      in_contact_o <= con_d;
      crashed_o    <= crash_d;
    end
  end

  assign out_valid_o = out_v_q;

  // A crash always reports contact and zero forces.
  `WGC_ASSERT_IMPL(a_crash_zero, clk_i, rst_ni, out_v_q && crashed_o,
    in_contact_o && force_y_o == 32'sd0 && torque_out_o == 32'sd0, "crash with force")
  // Without contact the whole result is zero.
  `WGC_ASSERT_IMPL(a_nocontact, clk_i, rst_ni, out_v_q && !in_contact_o,
    !crashed_o && force_x_o == 32'sd0 && force_y_o == 32'sd0, "force without contact")
  // A stalled result is held in the output register.
  `WGC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_v_q && out_stall_i,
    out_v_q && $stable(force_y_o), "stalled result lost")

endmodule
